@@ rtl/pct_pkg.sv @@
// Shared types, widths and constants for the Park/Clarke transform.
// Holds the quarter-wave sine table and the fixed-point scale factors.
// No dependencies.
package pct_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int ANGLE_W    = 9;
  localparam int IDX_W      = 7;
  localparam int TRIG_W     = 17;
  localparam int COEF_W     = 17;
  localparam int CK_W       = 11;
  localparam int SCALE_W    = 28;
  localparam int PROD_W     = 33;
  localparam int OPND_W     = 34;
  localparam int QUOT_W     = 20;
  localparam int SUM_W      = 22;
  localparam int LANES      = 6;
  localparam int TRIG_SHIFT = 15;

  // Divide by 1000: operand magnitude stays below 2**26 on that path.
  localparam int DIV_IN_W   = 27;
  localparam int RCP_SHIFT  = 36;
  localparam int RCP_PROD_W = 54;
  localparam logic [DIV_IN_W-1:0] RCP_1000 = 27'd68719477;

  // Pipeline depths
  localparam int TRIG_LAT   = 5;
  localparam int MUL_LAT    = 1;
  localparam int DIV_LAT    = 3;
  localparam int CTL_DEPTH  = TRIG_LAT + MUL_LAT + DIV_LAT + 1;
  localparam int RES_LAT    = CTL_DEPTH + 1;

  localparam logic [ANGLE_W-1:0] ANGLE_STEPS = 9'd360;
  localparam logic [ANGLE_W-1:0] QUARTER     = 9'd90;
  localparam logic [ANGLE_W-1:0] HALF_TURN   = 9'd180;
  localparam logic [ANGLE_W-1:0] THREE_Q     = 9'd270;

  localparam logic signed [CK_W-1:0] K500 = 11'sd500;
  localparam logic signed [CK_W-1:0] K866 = 11'sd866;
  localparam logic signed [CK_W-1:0] K667 = 11'sd667;
  localparam logic signed [CK_W-1:0] K333 = 11'sd333;
  localparam logic signed [CK_W-1:0] K577 = 11'sd577;

  typedef enum logic {
    OP_FWD = 1'b0,
    OP_INV = 1'b1
  } opcode_e;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [TRIG_W-1:0]   trig_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [OPND_W-1:0]   opnd_t;
  typedef logic signed [QUOT_W-1:0]   quot_t;

  typedef struct packed {
    logic    vld;
    opcode_e op;
  } ctl_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    sample_t            pa;
    sample_t            pb;
    sample_t            pc;
    sample_t            vd;
    sample_t            vq;
  } pay_t;

  // round(32768 * sin(k deg)), k = 0..90
  localparam logic [SAMPLE_W-1:0] SINE_Q [0:90] = '{
    0, 572, 1144, 1715, 2286, 2856, 3425, 3993, 4560, 5126,
    5690, 6252, 6813, 7371, 7927, 8481, 9032, 9580, 10126, 10668,
    11207, 11743, 12275, 12803, 13328, 13848, 14365, 14876, 15384, 15886,
    16384, 16877, 17364, 17847, 18324, 18795, 19261, 19720, 20174, 20622,
    21063, 21498, 21926, 22348, 22763, 23170, 23571, 23965, 24351, 24730,
    25102, 25466, 25822, 26170, 26510, 26842, 27166, 27482, 27789, 28088,
    28378, 28660, 28932, 29197, 29452, 29698, 29935, 30163, 30382, 30592,
    30792, 30983, 31164, 31336, 31499, 31651, 31795, 31928, 32052, 32166,
    32270, 32365, 32449, 32524, 32588, 32643, 32688, 32723, 32748, 32763,
    32768
  };

endpackage

@@ rtl/pct_trig.sv @@
// Angle reduction, sine/cosine lookup and lane coefficient generation.
// Five register stages. Depends on pct_pkg.
module pct_trig (
  input  logic                           clk_i,
  input  logic [pct_pkg::ANGLE_W-1:0]    angle_i,
  output pct_pkg::coef_t                 fwd_o [pct_pkg::LANES],
  output pct_pkg::coef_t                 inv_o [pct_pkg::LANES]
);
  import pct_pkg::*;

  logic [ANGLE_W-1:0]        deg_q;
  logic [IDX_W-1:0]          idx_s_q, idx_c_q;
  logic                      neg_s_q, neg_c_q;
  trig_t                     sin_q, cos_q;
  trig_t                     sin4_q, cos4_q;
  logic signed [SCALE_W-1:0] c500_q, c866_q, s500_q, s866_q;
  logic signed [SCALE_W-1:0] c667_q, c333_q, c577_q, s667_q, s333_q, s577_q;
  coef_t                     fwd_q [LANES];
  coef_t                     inv_q [LANES];

  logic [1:0]       quad, quad_c;
  logic [IDX_W-1:0] rem;
  trig_t            mag_s, mag_c;
  coef_t            c5, c8, s5, s8, c667, c333, c577, s667, s333, s577;

  // K * trig / 32768, truncated toward zero
  function automatic coef_t trunc15(input logic signed [SCALE_W-1:0] p);
    logic signed [SCALE_W-1:0]          b;
    logic signed [SCALE_W-TRIG_SHIFT-1:0] r;
    b = p + (p[SCALE_W-1] ? SCALE_W'(32767) : SCALE_W'(0));
    r = $signed(b[SCALE_W-1:TRIG_SHIFT]);
    return COEF_W'(r);
  endfunction

  always_comb begin
    priority if (deg_q < QUARTER) begin
      quad = 2'd0;
      rem  = IDX_W'(deg_q);
    end else if (deg_q < HALF_TURN) begin
      quad = 2'd1;
      rem  = IDX_W'(deg_q - QUARTER);
    end else if (deg_q < THREE_Q) begin
      quad = 2'd2;
      rem  = IDX_W'(deg_q - HALF_TURN);
    end else begin
      quad = 2'd3;
      rem  = IDX_W'(deg_q - THREE_Q);
    end
    quad_c = quad + 2'd1;
  end

  always_comb begin
    mag_s = trig_t'({1'b0, SINE_Q[idx_s_q]});
    mag_c = trig_t'({1'b0, SINE_Q[idx_c_q]});
  end

  always_comb begin
    c5   = trunc15(c500_q);
    c8   = trunc15(c866_q);
    s5   = trunc15(s500_q);
    s8   = trunc15(s866_q);
    c667 = trunc15(c667_q);
    c333 = trunc15(c333_q);
    c577 = trunc15(c577_q);
    s667 = trunc15(s667_q);
    s333 = trunc15(s333_q);
    s577 = trunc15(s577_q);
  end

  always_ff @(posedge clk_i) begin
    deg_q   <= (angle_i >= ANGLE_STEPS) ? angle_i - ANGLE_STEPS : angle_i;

    idx_s_q <= quad[0]   ? IDX_W'(QUARTER) - rem : rem;
    idx_c_q <= quad_c[0] ? IDX_W'(QUARTER) - rem : rem;
    neg_s_q <= quad[1];
    neg_c_q <= quad_c[1];

    sin_q   <= neg_s_q ? -mag_s : mag_s;
    cos_q   <= neg_c_q ? -mag_c : mag_c;

    sin4_q  <= sin_q;
    cos4_q  <= cos_q;
    c500_q  <= cos_q * K500;
    c866_q  <= cos_q * K866;
    s500_q  <= sin_q * K500;
    s866_q  <= sin_q * K866;
    c667_q  <= cos_q * K667;
    c333_q  <= cos_q * K333;
    c577_q  <= cos_q * K577;
    s667_q  <= sin_q * K667;
    s333_q  <= sin_q * K333;
    s577_q  <= sin_q * K577;

    fwd_q[0] <= cos4_q;
    fwd_q[1] <= s8 - c5;
    fwd_q[2] <= -c5 - s8;
    fwd_q[3] <= -sin4_q;
    fwd_q[4] <= s5 + c8;
    fwd_q[5] <= s5 - c8;
    inv_q[0] <= c667;
    inv_q[1] <= -s667;
    inv_q[2] <= s577 - c333;
    inv_q[3] <= s333 + c577;
    inv_q[4] <= -s577 - c333;
    inv_q[5] <= s333 - c577;
  end

  assign fwd_o = fwd_q;
  assign inv_o = inv_q;

endmodule

@@ rtl/pct_mul_lane.sv @@
// One multiplier lane: coefficient times sample, registered.
// Depends on pct_pkg.
module pct_mul_lane (
  input  logic             clk_i,
  input  pct_pkg::coef_t   coef_i,
  input  pct_pkg::sample_t smp_i,
  output pct_pkg::prod_t   prod_o
);
  import pct_pkg::*;

  prod_t prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= coef_i * smp_i;
  end

  assign prod_o = prod_q;

endmodule

@@ rtl/pct_div_lane.sv @@
// Truncating divide by 32768 (shift) or 1000 (reciprocal multiply).
// Three register stages: magnitude, divide, sign restore. Depends on pct_pkg.
module pct_div_lane (
  input  logic           clk_i,
  input  pct_pkg::opnd_t opnd_i,
  input  logic           pow2_i,
  output pct_pkg::quot_t quot_o
);
  import pct_pkg::*;

  logic                           neg_a_q, pow2_a_q;
  logic [OPND_W-1:0]              mag_a_q;
  logic                           neg_b_q, pow2_b_q;
  logic [OPND_W-TRIG_SHIFT-1:0]   shq_b_q;
  logic [RCP_PROD_W-1:0]          prd_b_q;
  quot_t                          quot_q;
  logic [QUOT_W-1:0]              qmag;

  always_comb begin
    qmag = pow2_b_q ? QUOT_W'(shq_b_q) : QUOT_W'(prd_b_q[RCP_PROD_W-1:RCP_SHIFT]);
  end

  always_ff @(posedge clk_i) begin
    neg_a_q  <= opnd_i[OPND_W-1];
    pow2_a_q <= pow2_i;
    mag_a_q  <= opnd_i[OPND_W-1] ? OPND_W'(-opnd_i) : OPND_W'(opnd_i);

    neg_b_q  <= neg_a_q;
    pow2_b_q <= pow2_a_q;
    shq_b_q  <= mag_a_q[OPND_W-1:TRIG_SHIFT];
    prd_b_q  <= mag_a_q[DIV_IN_W-1:0] * RCP_1000;

    quot_q   <= neg_b_q ? -quot_t'(qmag) : quot_t'(qmag);
  end

  assign quot_o = quot_q;

endmodule

@@ rtl/pct_merge.sv @@
// Merges lane quotients into d/q or a/b/c, saturates, drives the result beat.
// Depends on pct_pkg.
module pct_merge (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pct_pkg::ctl_t    ctl_i,
  input  pct_pkg::quot_t   quot_i [pct_pkg::LANES],
  output logic             res_valid_o,
  output pct_pkg::sample_t out_d_o,
  output pct_pkg::sample_t out_q_o,
  output pct_pkg::sample_t out_a_o,
  output pct_pkg::sample_t out_b_o,
  output pct_pkg::sample_t out_c_o
);
  import pct_pkg::*;

  localparam logic signed [SUM_W-1:0] SAT_MAX = 22'sd32767;
  localparam logic signed [SUM_W-1:0] SAT_MIN = -22'sd32768;

  logic                     res_valid_q;
  sample_t                  d_q, q_q, a_q, b_q, c_q;
  logic signed [SUM_W-1:0]  sum_d, sum_q;

  function automatic sample_t sat16(input logic signed [SUM_W-1:0] v);
    if (v > SAT_MAX) return SAMPLE_W'(SAT_MAX);
    if (v < SAT_MIN) return SAMPLE_W'(SAT_MIN);
    return SAMPLE_W'(v);
  endfunction

  always_comb begin
    sum_d = SUM_W'(quot_i[0]) + SUM_W'(quot_i[1]) + SUM_W'(quot_i[2]);
    sum_q = SUM_W'(quot_i[3]) + SUM_W'(quot_i[4]) + SUM_W'(quot_i[5]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (ctl_i.op)
      OP_FWD: begin
        d_q <= sat16(sum_d);
        q_q <= sat16(sum_q);
        a_q <= '0;
        b_q <= '0;
        c_q <= '0;
      end
      OP_INV: begin
        d_q <= '0;
        q_q <= '0;
        a_q <= sat16(SUM_W'(quot_i[0]));
        b_q <= sat16(SUM_W'(quot_i[2]));
        c_q <= sat16(SUM_W'(quot_i[4]));
      end
      default: begin
        d_q <= '0;
        q_q <= '0;
        a_q <= '0;
        b_q <= '0;
        c_q <= '0;
      end
    endcase
  end

  assign res_valid_o = res_valid_q;
  assign out_d_o     = d_q;
  assign out_q_o     = q_q;
  assign out_a_o     = a_q;
  assign out_b_o     = b_q;
  assign out_c_o     = c_q;

endmodule

@@ rtl/park_clarke_transform.sv @@
// Park/Clarke transform, forward abc->dq and inverse dq->abc, fixed point.
// Fully pipelined: one beat accepted every cycle, busy never asserts.
// The result strobe is registered; the path runs through the input register,
// trig lookup (5), multiply lanes (1), divide lanes (3) and merge (1).
// Reset clears only the control pipeline (valid and opcode); no state survives between beats.
// Results cannot be stalled: each beat is presented for exactly one cycle.
module park_clarke_transform (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        opcode_i,
  input  logic [pct_pkg::ANGLE_W-1:0] angle_deg_i,
  input  pct_pkg::sample_t            phase_a_i,
  input  pct_pkg::sample_t            phase_b_i,
  input  pct_pkg::sample_t            phase_c_i,
  input  pct_pkg::sample_t            axis_d_i,
  input  pct_pkg::sample_t            axis_q_i,
  output logic                        res_valid_o,
  output pct_pkg::sample_t            out_d_o,
  output pct_pkg::sample_t            out_q_o,
  output pct_pkg::sample_t            out_a_o,
  output pct_pkg::sample_t            out_b_o,
  output pct_pkg::sample_t            out_c_o
);
  import pct_pkg::*;

  ctl_t    ctl_q [CTL_DEPTH];
  pay_t    pay_q [TRIG_LAT+1];
  coef_t   fwd_coef [LANES];
  coef_t   inv_coef [LANES];
  sample_t fwd_smp [LANES];
  sample_t inv_smp [LANES];
  coef_t   lane_coef [LANES];
  sample_t lane_smp [LANES];
  prod_t   prod [LANES];
  opnd_t   opnd [LANES];
  logic    pow2 [LANES];
  quot_t   quot [LANES];
  ctl_t    ctl_mul, ctl_div;

  assign busy    = 1'b0;
  assign ctl_mul = ctl_q[TRIG_LAT];
  assign ctl_div = ctl_q[TRIG_LAT+MUL_LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < CTL_DEPTH; k++) begin
        ctl_q[k] <= '{vld: 1'b0, op: OP_FWD};
      end
    end else begin
      ctl_q[0] <= '{vld: start && !busy, op: opcode_e'(opcode_i)};
      for (int k = 1; k < CTL_DEPTH; k++) begin
        ctl_q[k] <= ctl_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pay_q[0] <= '{angle: angle_deg_i, pa: phase_a_i, pb: phase_b_i, pc: phase_c_i,
                  vd: axis_d_i, vq: axis_q_i};
    for (int k = 1; k <= TRIG_LAT; k++) begin
      pay_q[k] <= pay_q[k-1];
    end
  end

  pct_trig u_trig (
    .clk_i   (clk_i),
    .angle_i (pay_q[0].angle),
    .fwd_o   (fwd_coef),
    .inv_o   (inv_coef)
  );

  always_comb begin
    fwd_smp[0] = pay_q[TRIG_LAT].pa;
    fwd_smp[1] = pay_q[TRIG_LAT].pb;
    fwd_smp[2] = pay_q[TRIG_LAT].pc;
    fwd_smp[3] = pay_q[TRIG_LAT].pa;
    fwd_smp[4] = pay_q[TRIG_LAT].pb;
    fwd_smp[5] = pay_q[TRIG_LAT].pc;
    for (int m = 0; m < LANES/2; m++) begin
      inv_smp[2*m]   = pay_q[TRIG_LAT].vd;
      inv_smp[2*m+1] = pay_q[TRIG_LAT].vq;
    end
  end

  for (genvar j = 0; j < LANES; j++) begin : g_lane
    always_comb begin
      lane_coef[j] = (ctl_mul.op == OP_FWD) ? fwd_coef[j] : inv_coef[j];
      lane_smp[j]  = (ctl_mul.op == OP_FWD) ? fwd_smp[j]  : inv_smp[j];
    end

    pct_mul_lane u_mul (
      .clk_i  (clk_i),
      .coef_i (lane_coef[j]),
      .smp_i  (lane_smp[j]),
      .prod_o (prod[j])
    );

    pct_div_lane u_div (
      .clk_i  (clk_i),
      .opnd_i (opnd[j]),
      .pow2_i (pow2[j]),
      .quot_o (quot[j])
    );
  end

  // forward: each product divided on its own; inverse: pairs summed, then divided
  always_comb begin
    for (int m = 0; m < LANES/2; m++) begin
      if (ctl_div.op == OP_FWD) begin
        opnd[2*m]   = OPND_W'(prod[2*m]);
        opnd[2*m+1] = OPND_W'(prod[2*m+1]);
        pow2[2*m]   = (m == 0);
        pow2[2*m+1] = (m == 1);
      end else begin
        opnd[2*m]   = OPND_W'(prod[2*m]) + OPND_W'(prod[2*m+1]);
        opnd[2*m+1] = '0;
        pow2[2*m]   = 1'b0;
        pow2[2*m+1] = 1'b0;
      end
    end
  end

  pct_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl_q[CTL_DEPTH-1]),
    .quot_i      (quot),
    .res_valid_o (res_valid_o),
    .out_d_o     (out_d_o),
    .out_q_o     (out_q_o),
    .out_a_o     (out_a_o),
    .out_b_o     (out_b_o),
    .out_c_o     (out_c_o)
  );

  a_beat_from_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(start && !busy, RES_LAT))
    else $error("result beat without matching accepted beat");

  a_fwd_abc_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && ($past(opcode_i, RES_LAT) == OP_FWD) |->
      out_a_o == '0 && out_b_o == '0 && out_c_o == '0)
    else $error("forward beat carries nonzero phase outputs");

  a_inv_dq_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && ($past(opcode_i, RES_LAT) == OP_INV) |->
      out_d_o == '0 && out_q_o == '0)
    else $error("inverse beat carries nonzero axis outputs");

endmodule
